/* rtl/sitda_pkg.sv */
// Package for the signed integer to decimal ASCII unit.
// Holds the value width, derived BCD sizes, character codes and the state type.
// No dependencies.
package sitda_pkg;

  localparam int VALUE_WIDTH = 32;
  // decimal digits of 2**VALUE_WIDTH - 1 (1233/4096 ~ log10(2))
  localparam int NUM_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

endpackage

/* rtl/signed_integer_to_decimal_ascii_unit.sv */
// Signed integer to decimal ASCII converter, top level.
// Depends on sitda_pkg for widths, character codes and the state type.
// Conversion: bit-serial double dabble over all VALUE_WIDTH bits of the magnitude, then
// leading zero digits are skipped, before the first character is shown.
// Throughput: a new value is accepted only in idle, after the last character of the previous
// one is taken; one character per cycle on output while m_tready is high.
// Reset: synchronous active-high rst returns to idle with no output pending.
module signed_integer_to_decimal_ascii_unit
  import sitda_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [VALUE_WIDTH-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // [7:0] character
  output logic                   m_tlast    // final_char
);

  localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(VALUE_WIDTH - 1);
  localparam logic [DIG_CNT_W-1:0] DIG_ALL    = DIG_CNT_W'(NUM_DIGITS);
  localparam logic [DIG_CNT_W-1:0] DIG_ONE    = DIG_CNT_W'(1);

  state_t                 state, state_next;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_WIDTH-1:0]   bcd;
  logic [BCD_WIDTH-1:0]   bcd_adj;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIG_CNT_W-1:0]   dig_left;
  logic                   negative;
  logic [3:0]             top_digit;
  logic                   in_fire;
  logic                   out_fire;

  assign top_digit = bcd[BCD_WIDTH-1 -: 4];
  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    m_tdata    = CHAR_ZERO | {4'd0, top_digit};
    m_tlast    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt == BIT_LAST) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit != 4'd0 || dig_left == DIG_ONE) begin
          state_next = negative ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        m_tvalid = 1'b1;
        m_tdata  = CHAR_MINUS;
        if (m_tready) begin
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        m_tvalid = 1'b1;
        m_tlast  = (dig_left == DIG_ONE);
        if (m_tready && dig_left == DIG_ONE) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath: load magnitude, shift one bit per cycle into BCD, then drain digits
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          negative <= s_tdata[VALUE_WIDTH-1];
          mag      <= s_tdata[VALUE_WIDTH-1] ? (~s_tdata + VALUE_WIDTH'(1)) : s_tdata;
          bcd      <= '0;
          bit_cnt  <= '0;
          dig_left <= DIG_ALL;
        end
      end
      ST_CONV: begin
        bcd     <= {bcd_adj[BCD_WIDTH-2:0], mag[VALUE_WIDTH-1]};
        mag     <= {mag[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && dig_left != DIG_ONE) begin
          bcd      <= {bcd[BCD_WIDTH-5:0], 4'd0};
          dig_left <= dig_left - DIG_ONE;
        end
      end
      ST_DIGIT: begin
        if (out_fire) begin
          bcd      <= {bcd[BCD_WIDTH-5:0], 4'd0};
          dig_left <= dig_left - DIG_ONE;
        end
      end
      default: begin
        bcd <= bcd;
      end
    endcase
  end

endmodule

/* rtl/sitda_checker.sv */
// Port-level checker for the signed integer to decimal ASCII unit, with its bind.
// Depends on sitda_pkg for widths and character codes.
module sitda_checker
  import sitda_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [VALUE_WIDTH-1:0] s_tdata,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [7:0]             m_tdata,
  input logic                   m_tlast
);

  // hold a stalled character
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output pending");

  a_conv_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid && !s_tready)
    else $error("output right after accepted input");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == CHAR_MINUS) ||
                 (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_ZERO + 8'd9))
    else $error("character outside sign and digits");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata == CHAR_MINUS |-> !m_tlast)
    else $error("sign marked last");

endmodule

bind signed_integer_to_decimal_ascii_unit sitda_checker u_sitda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* tb/decimal_text_checker.sv */
`timescale 1ns / 100ps
// Checker for the signed integer to decimal ASCII unit: watches both streams,
// predicts the character run of every accepted value and compares in order.
// Depends on sitda_pkg for the value width and character codes.
module decimal_text_checker
  import sitda_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [VALUE_WIDTH-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [7:0]             m_tdata,   // [7:0] character
  input  logic                   m_tlast,   // final_char
  output int                     errors,
  output int                     outstanding
);

  typedef struct packed {
    logic [7:0] character;
    logic       final_char;
  } text_char_t;

  text_char_t expected_text[$];
  int         error_count = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value);
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [7:0]             digits[$];
    logic                   negative;
    negative  = value[VALUE_WIDTH-1];
    magnitude = negative ? (~value + 1'b1) : value;
    do begin
      digits.push_front(CHAR_ZERO + 8'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      expected_text.push_back('{character: CHAR_MINUS, final_char: 1'b0});
    end
    foreach (digits[i]) begin
      expected_text.push_back('{character: digits[i], final_char: i == digits.size() - 1});
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_text(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected item char=%0d last=%0b", m_tdata, m_tlast));
        end else begin
          want = expected_text.pop_front();
          if (m_tdata !== want.character) begin
            report_mismatch($sformatf("character %0d, expected %0d", m_tdata, want.character));
          end
          if (m_tlast !== want.final_char) begin
            report_mismatch($sformatf("last flag %0b, expected %0b on char %0d",
                                      m_tlast, want.final_char, want.character));
          end
        end
      end
    end
    errors      <= error_count;
    outstanding <= expected_text.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top of the testbench for signed_integer_to_decimal_ascii_unit: drives values with
// random gaps and output stalls, instantiates the checker and gives the verdict.
// Depends on sitda_pkg, the unit and decimal_text_checker.
module testbench;
  import sitda_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [VALUE_WIDTH-1:0] s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [7:0]             m_tdata;
  logic                   m_tlast;
  logic                   steady = 1'b0;
  int                     errors;
  int                     outstanding;

  signed_integer_to_decimal_ascii_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  decimal_text_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 31);
  end

  task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
    while (!steady && $urandom_range(0, 99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] random_value();
    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] power;
    int                     exponent;
    case ($urandom_range(0, 3))
      0: value = VALUE_WIDTH'($urandom());
      1: value = VALUE_WIDTH'($urandom_range(0, 999));
      2: begin
        exponent = $urandom_range(0, 9);
        power = VALUE_WIDTH'(1);
        repeat (exponent) power = power * 10;
        value = power + VALUE_WIDTH'($urandom_range(0, 2)) - 1'b1;
      end
      default: value = VALUE_WIDTH'($urandom()) >> $urandom_range(0, VALUE_WIDTH - 1);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      value = -value;
    end
    return value;
  endfunction

  initial begin
    logic [VALUE_WIDTH-1:0] directed[$];
    directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -5,
                 123456789, 999999999, 1000000000, -1000000000,
                 32'h7fffffff, 32'h80000001, 32'h80000000,
                 32'h55555555, 32'haaaaaaaa, 32'hfffffff6};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      send_value(directed[i]);
    end
    for (int i = 0; i < 200; i++) begin
      steady <= (i >= 90 && i < 140);
      send_value(random_value());
    end
    s_tvalid <= 1'b0;
    steady   <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/sitda_pkg.sv
rtl/signed_integer_to_decimal_ascii_unit.sv
rtl/sitda_checker.sv
tb/decimal_text_checker.sv
tb/testbench.sv
